@@ rtl/core/mpf_pkg.sv @@
// Shared types and constants for the MQTT PUBLISH framer.
// Used by mpf_front, mpf_queue, mpf_back and mqtt_publish_framer_unit.
`default_nettype none
package mpf_pkg;

    localparam int unsigned CAP_W    = 29;
    localparam int unsigned TLEN_W   = 16;
    localparam int unsigned PLEN_W   = 28;
    localparam int unsigned REM_W    = 28;
    localparam int unsigned QDEPTH   = 4;
    localparam int unsigned QPTR_W   = $clog2(QDEPTH);
    localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [7:0]       FIXED_HDR_PUBLISH = 8'h30;
    localparam logic [7:0]       RL_CONT_BIT       = 8'h80;
    localparam logic [CAP_W-1:0] CAP_RESET         = 29'd4096;

    // remaining-length byte count thresholds
    localparam logic [REM_W-1:0] RL_ONE_LIMIT   = 28'd128;
    localparam logic [REM_W-1:0] RL_TWO_LIMIT   = 28'd16384;
    localparam logic [REM_W-1:0] RL_THREE_LIMIT = 28'd2097152;

    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_RL_TOO_LARGE = 2'd1;
    localparam logic [1:0] STATUS_OVER_CAP     = 2'd2;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_DATA  = 1'b1;

    typedef enum logic [1:0] {
        CMD_DATA,
        CMD_HEADER,
        CMD_ERROR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [7:0]        data;
        logic              last;
        logic [1:0]        status;
        logic              retain;
        logic [2:0]        rl_count;
        logic [REM_W-1:0]  remaining;
        logic [TLEN_W-1:0] topic_length;
        logic              empty;
    } t_cmd;

endpackage
`default_nettype wire

@@ rtl/core/mpf_front.sv @@
// Front end: accepts items, tracks the open packet and classifies starts.
// Depends on mpf_pkg; feeds mpf_queue with t_cmd entries.
`default_nettype none
module mpf_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic                         i_full,
    input  wire logic                         i_req_type,
    input  wire logic [mpf_pkg::TLEN_W-1:0]   i_topic_length,
    input  wire logic [mpf_pkg::PLEN_W-1:0]   i_payload_length,
    input  wire logic                         i_retain_flag,
    input  wire logic [7:0]                   i_data_byte,
    input  wire logic [mpf_pkg::CAP_W-1:0]    i_capacity,
    output logic                              o_push,
    output mpf_pkg::t_cmd                     o_cmd
);
    import mpf_pkg::*;

    logic              r_open;
    logic [TLEN_W-1:0] r_topic_left;
    logic [PLEN_W-1:0] r_payload_left;
    logic              n_open;
    logic [TLEN_W-1:0] n_topic_left;
    logic [PLEN_W-1:0] n_payload_left;

    logic              accept;
    logic [REM_W:0]    remaining;
    logic [2:0]        rl_count;
    logic [REM_W+1:0]  total;
    logic              too_large;
    logic              over_cap;
    logic [TLEN_W-1:0] dec_topic;
    logic [PLEN_W-1:0] dec_payload;
    logic              data_final;

    assign accept    = i_valid && !i_full;
    assign remaining = (REM_W+1)'(2) + (REM_W+1)'(i_topic_length)
                     + (REM_W+1)'(i_payload_length);
    assign too_large = remaining[REM_W];

    always_comb begin
        if (remaining[REM_W-1:0] < RL_ONE_LIMIT) begin
            rl_count = 3'd1;
        end else if (remaining[REM_W-1:0] < RL_TWO_LIMIT) begin
            rl_count = 3'd2;
        end else if (remaining[REM_W-1:0] < RL_THREE_LIMIT) begin
            rl_count = 3'd3;
        end else begin
            rl_count = 3'd4;
        end
    end

    assign total    = (REM_W+2)'(remaining) + (REM_W+2)'(rl_count) + (REM_W+2)'(1);
    assign over_cap = total > (REM_W+2)'(i_capacity);

    // topic bytes count down first, then payload bytes
    always_comb begin
        dec_topic   = r_topic_left;
        dec_payload = r_payload_left;
        if (r_topic_left != '0) begin
            dec_topic = r_topic_left - TLEN_W'(1);
        end else if (r_payload_left != '0) begin
            dec_payload = r_payload_left - PLEN_W'(1);
        end
    end
    assign data_final = (dec_topic == '0) && (dec_payload == '0);

    always_comb begin
        n_open         = r_open;
        n_topic_left   = r_topic_left;
        n_payload_left = r_payload_left;
        o_push         = 1'b0;
        o_cmd          = '0;
        o_cmd.kind     = CMD_DATA;
        o_cmd.retain       = i_retain_flag;
        o_cmd.rl_count     = rl_count;
        o_cmd.remaining    = remaining[REM_W-1:0];
        o_cmd.topic_length = i_topic_length;
        o_cmd.empty        = (i_topic_length == '0) && (i_payload_length == '0);
        if (accept) begin
            if (i_req_type == REQ_START) begin
                o_push         = 1'b1;
                n_open         = 1'b0;
                n_topic_left   = '0;
                n_payload_left = '0;
                if (too_large) begin
                    o_cmd.kind   = CMD_ERROR;
                    o_cmd.last   = 1'b1;
                    o_cmd.status = STATUS_RL_TOO_LARGE;
                end else if (over_cap) begin
                    o_cmd.kind   = CMD_ERROR;
                    o_cmd.last   = 1'b1;
                    o_cmd.status = STATUS_OVER_CAP;
                end else begin
                    o_cmd.kind = CMD_HEADER;
                    if (!o_cmd.empty) begin
                        n_open         = 1'b1;
                        n_topic_left   = i_topic_length;
                        n_payload_left = i_payload_length;
                    end
                end
            end else if (r_open) begin
                o_push         = 1'b1;
                o_cmd.kind     = CMD_DATA;
                o_cmd.data     = i_data_byte;
                o_cmd.last     = data_final;
                o_cmd.status   = STATUS_OK;
                n_topic_left   = dec_topic;
                n_payload_left = dec_payload;
                n_open         = !data_final;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open         <= 1'b0;
            r_topic_left   <= '0;
            r_payload_left <= '0;
        end else begin
            r_open         <= n_open;
            r_topic_left   <= n_topic_left;
            r_payload_left <= n_payload_left;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/mpf_queue.sv @@
// Short command queue between front and back ends.
// Depends on mpf_pkg for t_cmd and the queue depth.
`default_nettype none
module mpf_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  mpf_pkg::t_cmd      i_cmd,
    input  wire logic          i_pop,
    output mpf_pkg::t_cmd      o_cmd,
    output logic               o_empty,
    output logic               o_full
);
    import mpf_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/mpf_back.sv @@
// Back end: expands header commands into bytes and drives the output register.
// Depends on mpf_pkg; pops t_cmd entries from mpf_queue.
`default_nettype none
module mpf_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  mpf_pkg::t_cmd      i_cmd,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [7:0]         o_out_byte,
    output logic               o_last_byte,
    output logic [1:0]         o_status
);
    import mpf_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_HEADER
    } t_state;

    t_state     r_state;
    t_cmd       r_hdr;
    logic [2:0] r_step;
    logic [7:0] r_byte;
    logic       r_last;
    logic [1:0] r_status;
    logic       r_valid;

    logic       advance;
    logic       final_step;
    logic [7:0] hdr_byte;
    logic       hdr_last;
    logic [6:0] rl_digit;

    assign advance    = !r_valid || !i_stall;
    assign o_pop      = advance && (r_state == ST_IDLE) && !i_empty;
    assign final_step = (r_step == r_hdr.rl_count + 3'd2);

    always_comb begin
        case (r_step)
            3'd1:    rl_digit = r_hdr.remaining[6:0];
            3'd2:    rl_digit = r_hdr.remaining[13:7];
            3'd3:    rl_digit = r_hdr.remaining[20:14];
            3'd4:    rl_digit = r_hdr.remaining[27:21];
            default: rl_digit = '0;
        endcase
    end

    // steps 1..rl are length digits, then topic length high and low
    always_comb begin
        hdr_last = 1'b0;
        if (r_step <= r_hdr.rl_count) begin
            hdr_byte = {1'b0, rl_digit};
            if (r_step < r_hdr.rl_count) begin
                hdr_byte = hdr_byte | RL_CONT_BIT;
            end
        end else if (r_step == r_hdr.rl_count + 3'd1) begin
            hdr_byte = r_hdr.topic_length[15:8];
        end else begin
            hdr_byte = r_hdr.topic_length[7:0];
            hdr_last = r_hdr.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= 1'b0;
            r_step   <= '0;
            r_hdr    <= '0;
            r_byte   <= '0;
            r_last   <= 1'b0;
            r_status <= STATUS_OK;
        end else if (advance) begin
            case (r_state)
                ST_HEADER: begin
                    r_valid  <= 1'b1;
                    r_byte   <= hdr_byte;
                    r_last   <= hdr_last;
                    r_status <= STATUS_OK;
                    if (final_step) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                ST_IDLE: begin
                    if (i_empty) begin
                        r_valid <= 1'b0;
                    end else begin
                        r_valid <= 1'b1;
                        case (i_cmd.kind)
                            CMD_HEADER: begin
                                r_byte   <= FIXED_HDR_PUBLISH | {7'd0, i_cmd.retain};
                                r_last   <= 1'b0;
                                r_status <= STATUS_OK;
                                r_hdr    <= i_cmd;
                                r_step   <= 3'd1;
                                r_state  <= ST_HEADER;
                            end
                            CMD_ERROR: begin
                                r_byte   <= '0;
                                r_last   <= 1'b1;
                                r_status <= i_cmd.status;
                            end
                            default: begin
                                r_byte   <= i_cmd.data;
                                r_last   <= i_cmd.last;
                                r_status <= STATUS_OK;
                            end
                        endcase
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_valid;
    assign o_out_byte  = r_byte;
    assign o_last_byte = r_last;
    assign o_status    = r_status;

endmodule
`default_nettype wire

@@ rtl/core/mqtt_publish_framer_unit.sv @@
// MQTT 3.1.1 QoS-0 PUBLISH framer, top level: config register and assembly.
// An accepted item is written into the queue, then into the output register when
// the output is free. Data items pass at 1 per cycle while the output is not
// stalled and no header is being expanded. A start item becomes the fixed header,
// 1-4 length bytes and 2 topic-length bytes, or one error byte if rejected.
// A 4-entry queue decouples input from output. Synchronous active-low reset
// clears all control state, sets buffer_capacity to 4096, leaves no packet open.
`default_nettype none
module mqtt_publish_framer_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic                         i_req_type,
    input  wire logic [mpf_pkg::TLEN_W-1:0]   i_topic_length,
    input  wire logic [mpf_pkg::PLEN_W-1:0]   i_payload_length,
    input  wire logic                         i_retain_flag,
    input  wire logic [7:0]                   i_data_byte,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [7:0]                        o_out_byte,
    output logic                              o_last_byte,
    output logic [1:0]                        o_status,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import mpf_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    logic             cfg_write;
    logic             push;
    logic             pop;
    logic             q_empty;
    logic             q_full;
    t_cmd             push_cmd;
    t_cmd             head_cmd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == 1'b0) ? {3'd0, r_capacity} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_write && (paddr[2] == 1'b0)) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    assign o_stall = q_full;

    mpf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_full           (q_full),
        .i_req_type       (i_req_type),
        .i_topic_length   (i_topic_length),
        .i_payload_length (i_payload_length),
        .i_retain_flag    (i_retain_flag),
        .i_data_byte      (i_data_byte),
        .i_capacity       (r_capacity),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    mpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    mpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte),
        .o_status    (o_status)
    );

endmodule
`default_nettype wire
